// File: rtl/core/llrp_pkg.sv
package llrp_pkg;

  localparam int NODES    = 16;
  localparam int REPLICAS = 3;

  localparam int LOAD_W = 24;
  localparam int AGE_W  = 16;
  localparam int IDX_W  = $clog2(NODES);
  localparam int CNT_W  = $clog2(NODES + 1);
  localparam int REP_W  = (REPLICAS > 1) ? $clog2(REPLICAS) : 1;
  localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;
  localparam int HB_W   = (IDX_W > 4) ? IDX_W : 4;

  localparam logic [1:0] FUNC_TICK      = 2'd0;
  localparam logic [1:0] FUNC_HEARTBEAT = 2'd1;
  localparam logic [1:0] FUNC_PLACE     = 2'd2;

  localparam logic [1:0] CFG_NODES_IN_USE  = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd1;

  typedef struct packed {
    logic              vld;
    logic [LOAD_W-1:0] load;
    logic [IDX_W-1:0]  idx;
  } slot_t;

  // Node zero is always in use; a count above NODES covers every node.
  function automatic logic node_used(input logic [IDX_W-1:0] i, input logic [4:0] n);
    return (i == '0) || (CMP_W'(i) < CMP_W'(n));
  endfunction

endpackage

// File: rtl/core/llrp_ram.sv
module llrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/llrp_rank.sv
module llrp_rank
  import llrp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   clear,
  input  slot_t                  cand,
  output slot_t [REPLICAS-1:0]   slots
);

  logic [REPLICAS:0]     ins;
  slot_t [REPLICAS:0]    src;
  slot_t [REPLICAS-1:0]  slots_next;

  // Keep the lowest loads in ascending order; an equal load never displaces
  // an earlier, lower-indexed node.
  always_comb begin
    ins    = '0;
    src[0] = cand;
    for (int p = 0; p < REPLICAS; p++) begin
      src[p+1] = slots[p];
      ins[p+1] = cand.vld && (!slots[p].vld || (cand.load < slots[p].load));
    end
    for (int p = 0; p < REPLICAS; p++) begin
      if (ins[p+1]) begin
        slots_next[p] = ins[p] ? src[p] : cand;
      end else begin
        slots_next[p] = src[p+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int p = 0; p < REPLICAS; p++) begin
        slots[p].vld <= 1'b0;
      end
    end else begin
      for (int p = 0; p < REPLICAS; p++) begin
        slots[p].vld <= slots_next[p].vld;
      end
    end
    for (int p = 0; p < REPLICAS; p++) begin
      slots[p].load <= slots_next[p].load;
      slots[p].idx  <= slots_next[p].idx;
    end
  end

endmodule

// File: rtl/core/least_loaded_replica_placer_top.sv
// Replica placer for a pool of storage nodes. Each node's 24-bit load and
// 16-bit age live in two synchronous RAMs. Every transaction (tick,
// heartbeat or place) sweeps all NODES entries once, reading both RAMs;
// a tick or heartbeat writes back ages and a place ranks the live in-use
// nodes by load. The sweep runs on past the last entry so that its read data
// can be processed, because of the RAM read latency. A place then writes the
// incremented loads of the chosen nodes, one at a time, and the result is
// loaded into the output register once that register is free. A new item is
// accepted only after the previous one has been loaded into the output
// register; in_ready is high only between items.
// The result sits in an output register, so the next item is accepted while
// it waits to be taken. Configuration writes are always accepted and are
// meant to be issued only while no item is in flight.
module least_loaded_replica_placer_top
  import llrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [3:0]  node,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] alive_mask,
  output logic [1:0]  placed_count,
  output logic [3:0]  first_node,
  output logic [3:0]  second_node,
  output logic [3:0]  third_node,
  output logic        no_node_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]        state;
  logic [4:0]        nodes_in_use;
  logic [AGE_W-1:0]  timeout_ticks;
  logic [1:0]        func_q;
  logic [3:0]        node_q;
  logic [CNT_W-1:0]  scan_cnt;
  logic              proc_vld;
  logic [IDX_W-1:0]  proc_idx;
  logic [REP_W-1:0]  wr_cnt;
  logic [NODES-1:0]  alive_acc;
  logic [NODES-1:0]  age_vld;
  logic [NODES-1:0]  load_vld;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [AGE_W-1:0]  age_rd;
  logic [LOAD_W-1:0] load_rd;

  logic              age_we;
  logic [AGE_W-1:0]  age_cur;
  logic [AGE_W-1:0]  age_new;
  logic              alive_now;
  logic              used_now;

  logic              load_we;
  logic [IDX_W-1:0]  load_waddr;
  logic [LOAD_W-1:0] load_wdata;
  slot_t             wr_slot;

  slot_t             cand;
  slot_t [REPLICAS-1:0] slots;
  logic              accept;
  logic              out_load;
  logic [1:0]        count;
  logic [3:0]        pick [3];

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  assign rd_en   = (state == S_SCAN) && (scan_cnt < CNT_W'(NODES));
  assign rd_addr = scan_cnt[IDX_W-1:0];

  // Age update for the entry whose read data has just come back.
  always_comb begin
    age_cur = age_vld[proc_idx] ? age_rd : '0;
    age_we  = 1'b0;
    age_new = age_cur;
    if (proc_vld) begin
      if (func_q == FUNC_TICK) begin
        age_we  = 1'b1;
        age_new = (age_cur != '1) ? age_cur + AGE_W'(1) : age_cur;
      end else if ((func_q == FUNC_HEARTBEAT) && (HB_W'(proc_idx) == HB_W'(node_q))) begin
        age_we  = 1'b1;
        age_new = '0;
      end
    end
    used_now  = node_used(proc_idx, nodes_in_use);
    alive_now = (age_new <= timeout_ticks) && used_now;

    cand.vld  = proc_vld && (func_q == FUNC_PLACE) && alive_now;
    cand.load = load_vld[proc_idx] ? load_rd : '0;
    cand.idx  = proc_idx;
  end

  // Load write-back of the chosen nodes, one per cycle.
  always_comb begin
    wr_slot    = slots[wr_cnt];
    load_we    = (state == S_WRITE) && (func_q == FUNC_PLACE) && wr_slot.vld;
    load_waddr = wr_slot.idx;
    load_wdata = (wr_slot.load != '1) ? wr_slot.load + LOAD_W'(1) : wr_slot.load;
  end

  llrp_ram #(.WIDTH(AGE_W), .DEPTH(NODES)) u_age_ram (
    .clk     (clk),
    .wr_en   (age_we),
    .wr_addr (proc_idx),
    .wr_data (age_new),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (age_rd)
  );

  llrp_ram #(.WIDTH(LOAD_W), .DEPTH(NODES)) u_load_ram (
    .clk     (clk),
    .wr_en   (load_we),
    .wr_addr (load_waddr),
    .wr_data (load_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (load_rd)
  );

  llrp_rank u_rank (
    .clk   (clk),
    .rst   (rst),
    .clear (accept),
    .cand  (cand),
    .slots (slots)
  );

  always_comb begin
    count = '0;
    for (int r = 0; r < 3; r++) begin
      pick[r] = '0;
    end
    for (int r = 0; r < REPLICAS; r++) begin
      if (slots[r].vld) begin
        count   = count + 2'd1;
        pick[r] = 4'(slots[r].idx);
      end
    end
  end

  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      nodes_in_use  <= 5'd16;
      timeout_ticks <= AGE_W'(30);
      scan_cnt      <= '0;
      proc_vld      <= 1'b0;
      wr_cnt        <= '0;
      age_vld       <= '0;
      load_vld      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_NODES_IN_USE) begin
          nodes_in_use <= cfg_data[4:0];
        end else if (cfg_index == CFG_TIMEOUT_TICKS) begin
          timeout_ticks <= cfg_data;
        end
      end

      proc_vld <= rd_en;
      if (age_we) begin
        age_vld[proc_idx] <= 1'b1;
      end
      if (load_we) begin
        load_vld[load_waddr] <= 1'b1;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            scan_cnt <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // The last entry is processed in the cycle the counter reaches NODES.
          if (scan_cnt == CNT_W'(NODES)) begin
            wr_cnt <= '0;
            state  <= S_WRITE;
          end else begin
            scan_cnt <= scan_cnt + CNT_W'(1);
          end
        end
        S_WRITE: begin
          if (wr_cnt == REP_W'(REPLICAS - 1)) begin
            state <= S_DONE;
          end else begin
            wr_cnt <= wr_cnt + REP_W'(1);
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= func;
      node_q <= node;
    end
    proc_idx <= rd_addr;
    if (proc_vld) begin
      alive_acc[proc_idx] <= alive_now;
    end
    if (out_load) begin
      alive_mask    <= 16'(alive_acc);
      placed_count  <= (func_q == FUNC_PLACE) ? count : 2'd0;
      first_node    <= (func_q == FUNC_PLACE) ? pick[0] : 4'd0;
      second_node   <= (func_q == FUNC_PLACE) ? pick[1] : 4'd0;
      third_node    <= (func_q == FUNC_PLACE) ? pick[2] : 4'd0;
      no_node_error <= (func_q == FUNC_PLACE) && !slots[0].vld;
    end
  end

endmodule
